// File: design/rcwc_pkg.sv
// ---------------------------------------------------------------------------
// rcwc_pkg
// Shared types and constants of the Reno congestion window controller.
// ---------------------------------------------------------------------------
`default_nettype none

package rcwc_pkg;

    localparam int CMD_W       = 2;
    localparam int ACK_ID_W    = 8;
    localparam int CFG_THR_W   = 10;
    localparam int PKT_OUT_W   = 10;
    localparam int FRAC_OUT_W  = 16;
    localparam int THR_OUT_W   = 10;
    localparam int BASE_OUT_W  = 8;
    localparam int KIND_W      = 3;
    localparam int DUP_CNT_W   = 8;
    localparam int S_TDATA_W   = 8;
    localparam int S_TUSER_W   = 3;
    localparam int M_TDATA_W   = 48;
    localparam int M_TUSER_W   = 3;
    localparam int APB_ADDR_W  = 3;
    localparam int APB_DATA_W  = 32;

    localparam logic [CMD_W-1:0] CMD_ACK     = 2'd0;
    localparam logic [CMD_W-1:0] CMD_TIMEOUT = 2'd1;
    localparam logic [CMD_W-1:0] CMD_RESTART = 2'd2;

    localparam logic [KIND_W-1:0] KIND_NEW_ACK   = 3'd0;
    localparam logic [KIND_W-1:0] KIND_DUPLICATE = 3'd1;
    localparam logic [KIND_W-1:0] KIND_DISCARDED = 3'd2;
    localparam logic [KIND_W-1:0] KIND_TIMEOUT   = 3'd3;
    localparam logic [KIND_W-1:0] KIND_RESTART   = 3'd4;

    localparam logic [DUP_CNT_W-1:0] DUP_CNT_MAX = 8'hFF;

    localparam logic REG_INIT_SSTHRESH = 1'b0;
    localparam logic [CFG_THR_W-1:0] INIT_SSTHRESH_RST = 10'd8;

    typedef struct packed {
        logic load_in;
        logic div_start;
        logic div_step;
        logic commit;
    } t_ctl_cmd;

    typedef struct packed {
        logic need_div;
        logic div_last;
        logic out_free;
    } t_dp_status;

endpackage

`default_nettype wire

// File: design/rcwc_ctrl.sv
// ---------------------------------------------------------------------------
// rcwc_ctrl
// Sequencer: accepts an event, runs the reciprocal divide when needed and
// commits the update once the output register can take the result.
// ---------------------------------------------------------------------------
`default_nettype none

module rcwc_ctrl (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  wire                       i_s_tvalid,
    output logic                      o_s_tready,
    input  wire rcwc_pkg::t_dp_status i_sts,
    output rcwc_pkg::t_ctl_cmd        o_cmd
);

    typedef enum logic [3:0] {
        S_IDLE   = 4'b0001,
        S_EVAL   = 4'b0010,
        S_DIV    = 4'b0100,
        S_COMMIT = 4'b1000
    } t_state;

    t_state r_state;
    t_state n_state;

    always_comb begin
        o_cmd           = '0;
        o_cmd.load_in   = (r_state == S_IDLE) && i_s_tvalid;
        o_cmd.div_start = (r_state == S_EVAL) && i_sts.need_div;
        o_cmd.div_step  = (r_state == S_DIV);
        o_cmd.commit    = (r_state == S_COMMIT) && i_sts.out_free;
        o_s_tready      = (r_state == S_IDLE);
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (i_s_tvalid) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                n_state = i_sts.need_div ? S_DIV : S_COMMIT;
            end
            S_DIV: begin
                if (i_sts.div_last) begin
                    n_state = S_COMMIT;
                end
            end
            S_COMMIT: begin
                if (i_sts.out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    a_eval_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EVAL) |-> $past(o_cmd.load_in))
        else $error("evaluation entered without an accepted transfer");

    a_div_ends_in_commit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && i_sts.div_last) |=> (r_state == S_COMMIT))
        else $error("divide finished without a commit");

endmodule

`default_nettype wire

// File: design/rcwc_datapath.sv
// ---------------------------------------------------------------------------
// rcwc_datapath
// Window state, event classification, bit-serial reciprocal divider and the
// output register.
// ---------------------------------------------------------------------------
`default_nettype none

module rcwc_datapath #(
    parameter int WINDOW_INT_BITS = 10,
    parameter int FRAC_BITS       = 16,
    parameter int DUP_THRESHOLD   = 3,
    parameter int ID_BITS         = 8
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire rcwc_pkg::t_ctl_cmd             i_cmd,
    output rcwc_pkg::t_dp_status                o_sts,
    input  wire [rcwc_pkg::CFG_THR_W-1:0]       i_init_thr,
    input  wire [rcwc_pkg::CMD_W-1:0]           i_in_cmd,
    input  wire [rcwc_pkg::ACK_ID_W-1:0]        i_in_ack_id,
    input  wire                                 i_in_ok,
    input  wire                                 i_m_tready,
    output logic                                o_m_tvalid,
    output logic [rcwc_pkg::M_TDATA_W-1:0]      o_m_tdata,
    output logic [rcwc_pkg::M_TUSER_W-1:0]      o_m_tuser
);

    localparam int WW  = WINDOW_INT_BITS + FRAC_BITS;
    localparam int LW  = (WINDOW_INT_BITS > rcwc_pkg::CFG_THR_W) ?
                         WINDOW_INT_BITS : rcwc_pkg::CFG_THR_W;
    localparam int CW  = $clog2(FRAC_BITS + 1);
    localparam logic [WW-1:0] ONE_PKT   = WW'(1) << FRAC_BITS;
    localparam logic [WW-1:0] DUP_FIXED = WW'(DUP_THRESHOLD) << FRAC_BITS;
    localparam logic [WW:0]   REM_INIT  = (WW + 1)'(1) << (FRAC_BITS - 1);
    localparam logic [FRAC_BITS:0] QUO_MAX = (FRAC_BITS + 1)'(1) << FRAC_BITS;
    localparam logic [LW-1:0] THR_MAX_X = LW'({WINDOW_INT_BITS{1'b1}});

    function automatic logic [WW-1:0] sat_add(input logic [WW-1:0] a,
                                              input logic [WW-1:0] b);
        logic [WW:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[WW] ? {WW{1'b1}} : s[WW-1:0];
    endfunction

    logic [WW-1:0]                   r_win;
    logic [WINDOW_INT_BITS-1:0]      r_thr;
    logic                            r_frec;
    logic [rcwc_pkg::DUP_CNT_W-1:0]  r_dup;
    logic [ID_BITS-1:0]              r_last_id;
    logic                            r_last_vld;
    logic [ID_BITS-1:0]              r_base;

    logic [rcwc_pkg::CMD_W-1:0]      r_cmd;
    logic [ID_BITS-1:0]              r_id;
    logic                            r_ok;

    logic [WW:0]                     r_rem;
    logic [FRAC_BITS:0]              r_quo;
    logic [CW-1:0]                   r_cnt;

    logic                            r_m_tvalid;
    logic [rcwc_pkg::M_TDATA_W-1:0]  r_m_tdata;
    logic [rcwc_pkg::M_TUSER_W-1:0]  r_m_tuser;

    logic [WW-1:0]                   n_win;
    logic [WINDOW_INT_BITS-1:0]      n_thr;
    logic                            n_frec;
    logic [rcwc_pkg::DUP_CNT_W-1:0]  n_dup;
    logic [ID_BITS-1:0]              n_last_id;
    logic                            n_last_vld;
    logic [ID_BITS-1:0]              n_base;
    logic [rcwc_pkg::KIND_W-1:0]     n_kind;

    logic                            is_dup;
    logic                            new_ack;
    logic                            slow_start;
    logic [WW-1:0]                   thr_fixed;
    logic [WINDOW_INT_BITS-1:0]      half_win;
    logic [WINDOW_INT_BITS-1:0]      thr_load;
    logic [LW-1:0]                   cfg_x;
    logic [rcwc_pkg::DUP_CNT_W-1:0]  dup_inc;
    logic [WW:0]                     rem_shift;
    logic                            rem_ge;

    assign is_dup     = r_last_vld && (r_id == r_last_id);
    assign new_ack    = (r_cmd == rcwc_pkg::CMD_ACK) && r_ok && (r_id == r_base) && !is_dup;
    assign thr_fixed  = {r_thr, {FRAC_BITS{1'b0}}};
    assign slow_start = (r_win < thr_fixed) || (r_win == '0);
    assign half_win   = r_win[WW-1:FRAC_BITS] >> 1;
    assign cfg_x      = LW'(i_init_thr);
    assign thr_load   = (cfg_x > THR_MAX_X) ? {WINDOW_INT_BITS{1'b1}}
                                            : WINDOW_INT_BITS'(cfg_x);
    assign dup_inc    = (r_dup != rcwc_pkg::DUP_CNT_MAX) ? r_dup + 1'b1 : r_dup;
    assign rem_shift  = {r_rem[WW-1:0], 1'b0};
    assign rem_ge     = (rem_shift >= {1'b0, r_win});

    assign o_sts.need_div = new_ack && !r_frec && !slow_start;
    assign o_sts.div_last = (r_cnt == CW'(FRAC_BITS));
    assign o_sts.out_free = !r_m_tvalid || i_m_tready;

    always_comb begin
        n_win      = r_win;
        n_thr      = r_thr;
        n_frec     = r_frec;
        n_dup      = r_dup;
        n_last_id  = r_last_id;
        n_last_vld = r_last_vld;
        n_base     = r_base;
        n_kind     = rcwc_pkg::KIND_DISCARDED;
        case (r_cmd)
            rcwc_pkg::CMD_ACK: begin
                if (new_ack) begin
                    n_kind     = rcwc_pkg::KIND_NEW_ACK;
                    n_last_id  = r_id;
                    n_last_vld = 1'b1;
                    n_dup      = '0;
                    n_base     = r_id + 1'b1;
                    if (r_frec) begin
                        n_win  = thr_fixed;
                        n_frec = 1'b0;
                    end else if (slow_start) begin
                        n_win = sat_add(r_win, ONE_PKT);
                    end else begin
                        n_win = sat_add(r_win, WW'(r_quo));
                    end
                end else if (is_dup) begin
                    n_kind = rcwc_pkg::KIND_DUPLICATE;
                    n_dup  = dup_inc;
                    if (!r_frec) begin
                        if (dup_inc == rcwc_pkg::DUP_CNT_W'(DUP_THRESHOLD)) begin
                            n_thr  = half_win;
                            n_win  = sat_add({half_win, {FRAC_BITS{1'b0}}}, DUP_FIXED);
                            n_frec = 1'b1;
                        end
                    end else begin
                        n_win = sat_add(r_win, ONE_PKT);
                    end
                end
            end
            rcwc_pkg::CMD_TIMEOUT: begin
                n_kind = rcwc_pkg::KIND_TIMEOUT;
                n_thr  = half_win;
                n_win  = ONE_PKT;
                n_dup  = '0;
                n_frec = 1'b0;
            end
            rcwc_pkg::CMD_RESTART: begin
                n_kind     = rcwc_pkg::KIND_RESTART;
                n_win      = ONE_PKT;
                n_thr      = thr_load;
                n_frec     = 1'b0;
                n_dup      = '0;
                n_last_id  = '0;
                n_last_vld = 1'b0;
                n_base     = '0;
            end
            default: begin
                n_kind = rcwc_pkg::KIND_DISCARDED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_win      <= ONE_PKT;
            r_thr      <= WINDOW_INT_BITS'(rcwc_pkg::INIT_SSTHRESH_RST);
            r_frec     <= 1'b0;
            r_dup      <= '0;
            r_last_id  <= '0;
            r_last_vld <= 1'b0;
            r_base     <= '0;
            r_m_tvalid <= 1'b0;
        end else begin
            if (i_cmd.commit) begin
                r_win      <= n_win;
                r_thr      <= n_thr;
                r_frec     <= n_frec;
                r_dup      <= n_dup;
                r_last_id  <= n_last_id;
                r_last_vld <= n_last_vld;
                r_base     <= n_base;
                r_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                r_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_cmd <= i_in_cmd;
            r_id  <= ID_BITS'(i_in_ack_id);
            r_ok  <= i_in_ok;
        end
        if (i_cmd.div_start) begin
            r_rem <= REM_INIT;
            r_quo <= '0;
            r_cnt <= '0;
        end else if (i_cmd.div_step) begin
            r_rem <= rem_ge ? (rem_shift - {1'b0, r_win}) : rem_shift;
            r_quo <= {r_quo[FRAC_BITS-1:0], rem_ge};
            r_cnt <= r_cnt + 1'b1;
        end
        if (i_cmd.commit) begin
            r_m_tdata <= {3'b000,
                          n_frec,
                          rcwc_pkg::BASE_OUT_W'(n_base),
                          rcwc_pkg::THR_OUT_W'(n_thr),
                          rcwc_pkg::FRAC_OUT_W'(n_win[FRAC_BITS-1:0]),
                          rcwc_pkg::PKT_OUT_W'(n_win[WW-1:FRAC_BITS])};
            r_m_tuser <= n_kind;
        end
    end

    assign o_m_tvalid = r_m_tvalid;
    assign o_m_tdata  = r_m_tdata;
    assign o_m_tuser  = r_m_tuser;

    a_window_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_win != '0) |-> (r_win >= ONE_PKT))
        else $error("nonzero window fell below one packet");

    a_quotient_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ($past(i_cmd.div_step) && $past(o_sts.div_last)) |-> (r_quo <= QUO_MAX))
        else $error("window increment exceeds one packet");

endmodule

`default_nettype wire

// File: design/reno_congestion_window_control.sv
// ---------------------------------------------------------------------------
// reno_congestion_window_control
// Reno style congestion window controller with slow start, congestion
// avoidance, fast recovery, timeout and restart events.
// ---------------------------------------------------------------------------
//  Channel   Direction  Signals                          Content
//  s_*       in         s_tvalid/s_tready/s_tdata/tuser  one event per transfer
//  m_*       out        m_tvalid/m_tready/m_tdata/tuser  window state per event
//  APB       in/out     psel/penable/pwrite/paddr/...    initial_ssthresh at 0x0
//
//  An event is accepted, evaluated and committed, with divide steps before the
//  commit when congestion avoidance needs the increment 2^(2*FRAC_BITS)/window;
//  the bit-serial divider produces one quotient bit per cycle, FRAC_BITS+1 bits in all.
//  One event is processed at a time; the next is taken once the result sits in
//  the output register, which holds it while m_tready is low.
//  Reset is synchronous and active low and needs no clearing pass.
// ---------------------------------------------------------------------------
`default_nettype none

module reno_congestion_window_control #(
    parameter int WINDOW_INT_BITS = 10,
    parameter int FRAC_BITS       = 16,
    parameter int DUP_THRESHOLD   = 3,
    parameter int ID_BITS         = 8
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    // APB configuration port
    input  wire                                 psel,
    input  wire                                 penable,
    input  wire                                 pwrite,
    input  wire  [rcwc_pkg::APB_ADDR_W-1:0]     paddr,
    input  wire  [rcwc_pkg::APB_DATA_W-1:0]     pwdata,
    output logic [rcwc_pkg::APB_DATA_W-1:0]     prdata,
    output logic                                pready,
    // Event input
    input  wire                                 s_tvalid,
    output logic                                s_tready,
    input  wire  [rcwc_pkg::S_TDATA_W-1:0]      s_tdata,  // ack_id[7:0]
    input  wire  [rcwc_pkg::S_TUSER_W-1:0]      s_tuser,  // cmd[1:0], checksum_ok[2]
    // Window output
    output logic                                m_tvalid,
    input  wire                                 m_tready,
    output logic [rcwc_pkg::M_TDATA_W-1:0]      m_tdata,  // window_packets[9:0],
                                                          // window_fraction[25:10],
                                                          // threshold_now[35:26],
                                                          // base_id[43:36],
                                                          // recovering[44]
    output logic [rcwc_pkg::M_TUSER_W-1:0]      m_tuser   // event_kind[2:0]
);

    logic [rcwc_pkg::CFG_THR_W-1:0] r_init_thr;
    rcwc_pkg::t_ctl_cmd             ctl_cmd;
    rcwc_pkg::t_dp_status           dp_sts;

    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init_thr <= rcwc_pkg::INIT_SSTHRESH_RST;
        end else if (psel && penable && pwrite && pready &&
                     (paddr[2] == rcwc_pkg::REG_INIT_SSTHRESH)) begin
            r_init_thr <= pwdata[rcwc_pkg::CFG_THR_W-1:0];
        end
    end

    always_comb begin
        prdata = '0;
        if (paddr[2] == rcwc_pkg::REG_INIT_SSTHRESH) begin
            prdata = rcwc_pkg::APB_DATA_W'(r_init_thr);
        end
    end

    rcwc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_tvalid),
        .o_s_tready (s_tready),
        .i_sts      (dp_sts),
        .o_cmd      (ctl_cmd)
    );

    rcwc_datapath #(
        .WINDOW_INT_BITS (WINDOW_INT_BITS),
        .FRAC_BITS       (FRAC_BITS),
        .DUP_THRESHOLD   (DUP_THRESHOLD),
        .ID_BITS         (ID_BITS)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (ctl_cmd),
        .o_sts       (dp_sts),
        .i_init_thr  (r_init_thr),
        .i_in_cmd    (s_tuser[1:0]),
        .i_in_ack_id (s_tdata),
        .i_in_ok     (s_tuser[2]),
        .i_m_tready  (m_tready),
        .o_m_tvalid  (m_tvalid),
        .o_m_tdata   (m_tdata),
        .o_m_tuser   (m_tuser)
    );

endmodule

`default_nettype wire

// File: tb/reno_congestion_window_control_checker.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// reno_congestion_window_control_checker
// Watches the event, window and register channels of the congestion window
// controller. It keeps its own copy of the window state and the slow start
// configuration, predicts one window report per accepted event, and compares
// every report that leaves the block with the oldest prediction. Register
// read-backs are checked against the configuration copy. The number of
// mismatches and of reports still due are handed to the testbench top.
// ---------------------------------------------------------------------------
module reno_congestion_window_control_checker (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               i_psel,
    input  wire                               i_penable,
    input  wire                               i_pwrite,
    input  wire  [rcwc_pkg::APB_ADDR_W-1:0]   i_paddr,
    input  wire  [rcwc_pkg::APB_DATA_W-1:0]   i_pwdata,
    input  wire  [rcwc_pkg::APB_DATA_W-1:0]   i_prdata,
    input  wire                               i_pready,
    input  wire                               i_s_tvalid,
    input  wire                               i_s_tready,
    input  wire  [rcwc_pkg::S_TDATA_W-1:0]    i_s_tdata,  // ack_id[7:0]
    input  wire  [rcwc_pkg::S_TUSER_W-1:0]    i_s_tuser,  // cmd[1:0], checksum_ok[2]
    input  wire                               i_m_tvalid,
    input  wire                               i_m_tready,
    input  wire  [rcwc_pkg::M_TDATA_W-1:0]    i_m_tdata,  // packets, fraction,
                                                          // threshold, base,
                                                          // recovering
    input  wire  [rcwc_pkg::M_TUSER_W-1:0]    i_m_tuser,  // event_kind[2:0]
    output int                                o_mismatches,
    output int                                o_reports_due
);

    localparam int PKT_W     = rcwc_pkg::PKT_OUT_W;
    localparam int FRAC_W    = rcwc_pkg::FRAC_OUT_W;
    localparam int THR_W     = rcwc_pkg::THR_OUT_W;
    localparam int BASE_W    = rcwc_pkg::BASE_OUT_W;
    localparam int KIND_W    = rcwc_pkg::KIND_W;
    localparam int ID_W      = rcwc_pkg::ACK_ID_W;
    localparam int CMD_W     = rcwc_pkg::CMD_W;
    localparam int CFG_W     = rcwc_pkg::CFG_THR_W;
    localparam int DUP_W     = rcwc_pkg::DUP_CNT_W;
    localparam int WIN_W     = PKT_W + FRAC_W;
    localparam int DUP_LIMIT = 3;
    localparam int FRAC_LSB  = PKT_W;
    localparam int THR_LSB   = FRAC_LSB + FRAC_W;
    localparam int BASE_LSB  = THR_LSB + THR_W;
    localparam int REC_BIT   = BASE_LSB + BASE_W;
    localparam int DUE_DEPTH = 16;

    localparam logic [WIN_W-1:0] ONE_PKT = WIN_W'(1) << FRAC_W;
    localparam logic [WIN_W-1:0] WIN_MAX = '1;
    localparam logic [rcwc_pkg::APB_ADDR_W-1:0] ADDR_INIT_SSTHRESH =
        rcwc_pkg::APB_ADDR_W'(4 * int'(rcwc_pkg::REG_INIT_SSTHRESH));

    typedef struct packed {
        logic [PKT_W-1:0]  packets;
        logic [FRAC_W-1:0] fraction;
        logic [THR_W-1:0]  threshold;
        logic [BASE_W-1:0] base;
        logic              recovering;
        logic [KIND_W-1:0] kind;
    } t_window_report;

    logic [CFG_W-1:0]  cfg_ssthresh;
    logic [WIN_W-1:0]  cwnd;
    logic [THR_W-1:0]  ssthresh;
    logic              in_recovery;
    logic [DUP_W-1:0]  dup_seen;
    logic [ID_W-1:0]   last_id;
    logic              last_id_seen;
    logic [ID_W-1:0]   base;

    t_window_report due_ring [DUE_DEPTH];
    int due_wr = 0;
    int due_rd = 0;
    int due_count = 0;
    int mismatches = 0;

    initial begin
        o_mismatches = 0;
        o_reports_due = 0;
    end

    function automatic void restart_window();
        cwnd = ONE_PKT;
        ssthresh = cfg_ssthresh;
        in_recovery = 1'b0;
        dup_seen = '0;
        last_id = '0;
        last_id_seen = 1'b0;
        base = '0;
    endfunction

    function automatic logic [WIN_W-1:0] grow(logic [WIN_W-1:0] win, logic [63:0] inc);
        logic [63:0] sum;
        sum = 64'(win) + inc;
        return (sum > 64'(WIN_MAX)) ? WIN_MAX : sum[WIN_W-1:0];
    endfunction

    function automatic t_window_report advance_window(logic [CMD_W-1:0] cmd,
                                                      logic [ID_W-1:0] id,
                                                      logic ok);
        t_window_report r;
        logic is_dup;
        logic [WIN_W-1:0] thr_window;
        r.kind = rcwc_pkg::KIND_DISCARDED;
        is_dup = last_id_seen && id == last_id;
        thr_window = WIN_W'(ssthresh) << FRAC_W;
        case (cmd)
            rcwc_pkg::CMD_ACK: begin
                if (ok && id == base && !is_dup) begin
                    r.kind = rcwc_pkg::KIND_NEW_ACK;
                    last_id = id;
                    last_id_seen = 1'b1;
                    dup_seen = '0;
                    base = id + 1'b1;
                    if (in_recovery) begin
                        cwnd = thr_window;
                        in_recovery = 1'b0;
                    end else if (cwnd < thr_window || cwnd == '0) begin
                        cwnd = grow(cwnd, 64'(ONE_PKT));
                    end else begin
                        cwnd = grow(cwnd, (64'd1 << (2 * FRAC_W)) / 64'(cwnd));
                    end
                end else if (is_dup) begin
                    r.kind = rcwc_pkg::KIND_DUPLICATE;
                    if (dup_seen != rcwc_pkg::DUP_CNT_MAX)
                        dup_seen = dup_seen + 1'b1;
                    if (!in_recovery) begin
                        if (dup_seen == DUP_W'(DUP_LIMIT)) begin
                            ssthresh = THR_W'(cwnd[WIN_W-1:FRAC_W] >> 1);
                            cwnd = grow(WIN_W'(ssthresh) << FRAC_W,
                                        64'(DUP_LIMIT) << FRAC_W);
                            in_recovery = 1'b1;
                        end
                    end else begin
                        cwnd = grow(cwnd, 64'(ONE_PKT));
                    end
                end
            end
            rcwc_pkg::CMD_TIMEOUT: begin
                r.kind = rcwc_pkg::KIND_TIMEOUT;
                ssthresh = THR_W'(cwnd[WIN_W-1:FRAC_W] >> 1);
                cwnd = ONE_PKT;
                dup_seen = '0;
                in_recovery = 1'b0;
            end
            rcwc_pkg::CMD_RESTART: begin
                r.kind = rcwc_pkg::KIND_RESTART;
                restart_window();
            end
            default: ;
        endcase
        r.packets = cwnd[WIN_W-1:FRAC_W];
        r.fraction = cwnd[FRAC_W-1:0];
        r.threshold = ssthresh;
        r.base = base;
        r.recovering = in_recovery;
        return r;
    endfunction

    always @(posedge i_clk) begin : monitor
        t_window_report want;
        t_window_report got;
        if (!i_rst_n) begin
            cfg_ssthresh = rcwc_pkg::INIT_SSTHRESH_RST;
            restart_window();
            due_wr = 0;
            due_rd = 0;
            due_count = 0;
        end else begin
            if (i_psel && i_penable && i_pready && i_paddr == ADDR_INIT_SSTHRESH) begin
                if (i_pwrite) begin
                    cfg_ssthresh = i_pwdata[CFG_W-1:0];
                end else if (i_prdata != rcwc_pkg::APB_DATA_W'(cfg_ssthresh)) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("initial_ssthresh read: expected %0d, got %0d",
                                 cfg_ssthresh, i_prdata);
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                got.packets = i_m_tdata[0 +: PKT_W];
                got.fraction = i_m_tdata[FRAC_LSB +: FRAC_W];
                got.threshold = i_m_tdata[THR_LSB +: THR_W];
                got.base = i_m_tdata[BASE_LSB +: BASE_W];
                got.recovering = i_m_tdata[REC_BIT];
                got.kind = i_m_tuser[KIND_W-1:0];
                if (due_count == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected window transfer: pkts %0d frac %h kind %0d",
                                 got.packets, got.fraction, got.kind);
                end else begin
                    want = due_ring[due_rd];
                    due_rd = (due_rd + 1) % DUE_DEPTH;
                    due_count--;
                    if (got != want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"window mismatch at %0t: expected pkts %0d frac %h ",
                                      "thr %0d base %0d rec %0d kind %0d; got pkts %0d ",
                                      "frac %h thr %0d base %0d rec %0d kind %0d"},
                                     $realtime, want.packets, want.fraction,
                                     want.threshold, want.base, want.recovering,
                                     want.kind, got.packets, got.fraction,
                                     got.threshold, got.base, got.recovering, got.kind);
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                want = advance_window(i_s_tuser[CMD_W-1:0],
                                      i_s_tdata[ID_W-1:0],
                                      i_s_tuser[CMD_W]);
                if (due_count < DUE_DEPTH) begin
                    due_ring[due_wr] = want;
                    due_wr = (due_wr + 1) % DUE_DEPTH;
                    due_count++;
                end else begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("event accepted with %0d window reports outstanding",
                                 due_count);
                end
            end
        end
        o_mismatches <= mismatches;
        o_reports_due <= due_count;
    end

endmodule

// File: tb/reno_congestion_window_control_tb.sv
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// reno_congestion_window_control_tb
// Drives ACK, duplicate, timeout, restart and malformed events into the
// congestion window controller: a short directed sequence through slow start,
// fast recovery, a zero window and avoidance, then random traffic built
// mostly from in-order ACK runs and duplicate runs under several slow start
// thresholds. A separate checker predicts and compares every window report.
// ---------------------------------------------------------------------------
module reno_congestion_window_control_tb;

    localparam int WATCHDOG_LIMIT = 2000;
    localparam int LONG_HOLD = 80;
    localparam int CMD_W = rcwc_pkg::CMD_W;
    localparam int ID_W = rcwc_pkg::ACK_ID_W;
    localparam int ADDR_W = rcwc_pkg::APB_ADDR_W;
    localparam int DATA_W = rcwc_pkg::APB_DATA_W;
    localparam int CFG_W = rcwc_pkg::CFG_THR_W;
    localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
    localparam logic [ADDR_W-1:0] ADDR_INIT_SSTHRESH =
        ADDR_W'(4 * int'(rcwc_pkg::REG_INIT_SSTHRESH));

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [ADDR_W-1:0] paddr = '0;
    logic [DATA_W-1:0] pwdata = '0;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    logic                               s_tvalid = 1'b0;
    logic                               s_tready;
    logic [rcwc_pkg::S_TDATA_W-1:0]     s_tdata = '0;
    logic [rcwc_pkg::S_TUSER_W-1:0]     s_tuser = '0;

    logic                               m_tvalid;
    logic                               m_tready = 1'b1;
    logic [rcwc_pkg::M_TDATA_W-1:0]     m_tdata;
    logic [rcwc_pkg::M_TUSER_W-1:0]     m_tuser;

    int mismatches;
    int reports_due;
    int quiet_cycles = 0;
    int events_sent = 0;
    bit idling = 1'b1;
    bit long_hold = 1'b0;

    logic [ID_W-1:0] next_base = '0;
    logic [ID_W-1:0] last_acked = '0;
    logic            ack_seen = 1'b0;

    always #5 i_clk = ~i_clk;

    reno_congestion_window_control uut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    reno_congestion_window_control_checker window_checker (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_psel        (psel),
        .i_penable     (penable),
        .i_pwrite      (pwrite),
        .i_paddr       (paddr),
        .i_pwdata      (pwdata),
        .i_prdata      (prdata),
        .i_pready      (pready),
        .i_s_tvalid    (s_tvalid),
        .i_s_tready    (s_tready),
        .i_s_tdata     (s_tdata),
        .i_s_tuser     (s_tuser),
        .i_m_tvalid    (m_tvalid),
        .i_m_tready    (m_tready),
        .i_m_tdata     (m_tdata),
        .i_m_tuser     (m_tuser),
        .o_mismatches  (mismatches),
        .o_reports_due (reports_due)
    );

    // Called right after a rising edge; returns at the edge of the transfer
    // with tvalid still high so that back-to-back events need no toggle.
    task automatic send_event(input logic [CMD_W-1:0] cmd,
                              input logic [ID_W-1:0] id,
                              input logic ok);
        if (idling && $urandom_range(0, 5) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= id;
        s_tuser <= {ok, cmd};
        do @(posedge i_clk); while (!s_tready);
        events_sent++;
        if (cmd == rcwc_pkg::CMD_ACK) begin
            if (ok && id == next_base && !(ack_seen && id == last_acked)) begin
                last_acked = id;
                ack_seen = 1'b1;
                next_base = id + 1'b1;
            end
        end else if (cmd == rcwc_pkg::CMD_RESTART) begin
            next_base = '0;
            last_acked = '0;
            ack_seen = 1'b0;
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge i_clk);
        while (reports_due != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apb_access(input logic write, input logic [DATA_W-1:0] data);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= write;
        paddr <= ADDR_INIT_SSTHRESH;
        pwdata <= data;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic random_burst();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 45 || (pick < 70 && !ack_seen)) begin
            repeat ($urandom_range(1, 8)) send_event(rcwc_pkg::CMD_ACK, next_base, 1'b1);
        end else if (pick < 70) begin
            repeat ($urandom_range(1, 6))
                send_event(rcwc_pkg::CMD_ACK, last_acked, 1'($urandom_range(0, 1)));
        end else if (pick < 77) begin
            send_event(rcwc_pkg::CMD_TIMEOUT, 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
        end else if (pick < 79) begin
            send_event(rcwc_pkg::CMD_RESTART, 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
        end else if (pick < 83) begin
            send_event(CMD_UNUSED, 8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
        end else if (pick < 90) begin
            send_event(rcwc_pkg::CMD_ACK, next_base, 1'b0);
        end else begin
            send_event(rcwc_pkg::CMD_ACK, 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
        end
    endtask

    initial begin : window_sink
        forever begin
            @(posedge i_clk);
            if (long_hold) begin
                long_hold = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                m_tready <= 1'b1;
            end else if (idling && $urandom_range(0, 4) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
                m_tready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("reno_congestion_window_control_tb failed");
            $finish;
        end
    end

    initial begin : stimulus
        logic [CFG_W-1:0] thr_plan [5];
        int phase_end;
        thr_plan = '{10'd0, 10'd1023, 10'd0, 10'd1, 10'd8};
        thr_plan[2] = CFG_W'($urandom_range(2, 1022));
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Checksum failure and wrong id before any ACK, then recovery entry,
        // growth in recovery and exit with the window set to the threshold.
        send_event(rcwc_pkg::CMD_ACK, 8'd0, 1'b0);
        send_event(rcwc_pkg::CMD_ACK, 8'd5, 1'b1);
        send_event(rcwc_pkg::CMD_ACK, 8'd0, 1'b1);
        send_event(rcwc_pkg::CMD_ACK, 8'd0, 1'b1);
        send_event(rcwc_pkg::CMD_ACK, 8'd0, 1'b0);
        send_event(rcwc_pkg::CMD_ACK, 8'd0, 1'b1);
        send_event(rcwc_pkg::CMD_ACK, 8'd0, 1'b1);
        send_event(rcwc_pkg::CMD_ACK, 8'd1, 1'b1);
        // Drive the threshold to zero so that leaving recovery gives a zero
        // window, which the next ACK grows by a whole packet.
        send_event(rcwc_pkg::CMD_TIMEOUT, 8'd0, 1'b0);
        repeat (3) send_event(rcwc_pkg::CMD_ACK, 8'd1, 1'b1);
        send_event(rcwc_pkg::CMD_ACK, 8'd2, 1'b1);
        send_event(rcwc_pkg::CMD_ACK, 8'd3, 1'b1);
        send_event(CMD_UNUSED, 8'd255, 1'b1);
        send_event(rcwc_pkg::CMD_RESTART, 8'd0, 1'b0);
        send_event(rcwc_pkg::CMD_ACK, 8'd255, 1'b1);
        for (int i = 0; i < 9; i++)
            send_event(rcwc_pkg::CMD_ACK, 8'(i), 1'b1);

        for (int p = 0; p < 5; p++) begin
            drain();
            apb_access(1'b1, DATA_W'(thr_plan[p]));
            apb_access(1'b0, '0);
            idling = (p != 4);
            if (p == 2)
                long_hold = 1'b1;
            send_event(rcwc_pkg::CMD_RESTART, 8'($urandom_range(0, 255)),
                       1'($urandom_range(0, 1)));
            if (p == 1) begin
                // Long duplicate run: saturates the duplicate count and the window.
                send_event(rcwc_pkg::CMD_ACK, next_base, 1'b1);
                repeat (1030)
                    send_event(rcwc_pkg::CMD_ACK, last_acked, 1'($urandom_range(0, 1)));
            end
            if (p == 3)
                repeat (260) send_event(rcwc_pkg::CMD_ACK, next_base, 1'b1);
            phase_end = events_sent + 90;
            while (events_sent < phase_end)
                random_burst();
        end

        drain();
        repeat (30) @(posedge i_clk);
        if (mismatches == 0 && reports_due == 0)
            $display("reno_congestion_window_control_tb passed");
        else
            $display("reno_congestion_window_control_tb failed");
        $finish;
    end

endmodule

// File: files.f
design/rcwc_pkg.sv
design/rcwc_ctrl.sv
design/rcwc_datapath.sv
design/reno_congestion_window_control.sv
tb/reno_congestion_window_control_checker.sv
tb/reno_congestion_window_control_tb.sv
